// ===== design/swt_pkg.sv =====
// Shared types, constants and byte folding for the sorted word table.
package swt_pkg;

    localparam int unsigned KeyBits = 80;
    localparam int unsigned WordLenBits = 4;
    localparam int unsigned MinChars = 3;
    localparam int unsigned CountBits = 11;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    localparam logic [0:0] REG_CHAR_LEN = 1'b0;

    typedef logic [KeyBits-1:0] key_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture key, start search bounds
        logic probe;      // issue read at midpoint
        logic step;       // apply compare to bounds
        logic chk_rd;     // issue read at lower bound
        logic chk;        // latch hit
        logic shift_rd;   // read entry about to be shifted
        logic shift_wr;   // write shifted entry, step down
        logic ins_wr;     // write new key, bump count
    } swt_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic search_done;
        logic hit;
        logic is_lookup;
        logic full;
        logic shift_done;
    } swt_sts_t;

    function automatic logic [7:0] fold_byte(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b == 8'ha8 || b == 8'hb8) r = 8'he5;
        else if (b >= 8'hc0 && b < 8'he0) r = b + 8'h20;
        return r;
    endfunction

    function automatic key_t fold_key(input key_t k);
        key_t r;
        for (int i = 0; i < KeyBits / 8; i++) r[8*i +: 8] = fold_byte(k[8*i +: 8]);
        return r;
    endfunction

endpackage

// ===== design/swt_datapath.sv =====
// Datapath: key register, word memory, search bounds and shift pointer.
module swt_datapath #(
    parameter int unsigned TABLE_DEPTH = 1024,
    parameter int unsigned MAX_CHARS = 10
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  swt_pkg::swt_cmd_t       cmd,
    output swt_pkg::swt_sts_t       sts,
    input  logic                    req_type,
    input  logic [15:0]             word_high,
    input  logic [63:0]             word_low,
    input  logic [3:0]              char_len,
    output logic [swt_pkg::CountBits-1:0] entry_count
);
    import swt_pkg::*;

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

    key_t mem [TABLE_DEPTH];
    key_t rd_data_reg;

    key_t key_reg;
    logic lookup_reg;
    logic [CW-1:0] lo_reg, hi_reg, cnt_reg, ptr_reg;
    logic hit_reg;

    // effective length and masking of unused characters
    logic [3:0] len;
    key_t raw_key, mask;
    always_comb begin
        len = char_len;
        if (len < 4'(MinChars)) len = 4'(MinChars);
        if (len > 4'(MAX_CHARS)) len = 4'(MAX_CHARS);
        raw_key = {word_high, word_low};
        for (int i = 0; i < KeyBits / 8; i++)
            mask[KeyBits-1-8*i -: 8] = (4'(i) < len) ? 8'hff : 8'h00;
    end

    key_t masked;
    assign masked = raw_key & mask;

    logic [CW-1:0] mid;
    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);

    // memory read address selection
    logic [CW-1:0] rd_addr;
    always_comb begin
        rd_addr = lo_reg;
        if (cmd.probe) rd_addr = mid;
        else if (cmd.shift_rd) rd_addr = ptr_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr[AW-1:0]];
        if (cmd.shift_wr) mem[ptr_reg[AW-1:0]] <= rd_data_reg;
        else if (cmd.ins_wr) mem[lo_reg[AW-1:0]] <= key_reg;
    end

    // mid of the last probe is held for the step
    logic [CW-1:0] pmid_reg;
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            lookup_reg <= req_type;
            key_reg <= (req_type == REQ_LOOKUP) ? masked : fold_key(masked);
        end
        if (cmd.probe) pmid_reg <= mid;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            lo_reg  <= '0;
            hi_reg  <= '0;
            ptr_reg <= '0;
            hit_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                lo_reg <= '0;
                hi_reg <= cnt_reg;
            end
            if (cmd.step) begin
                if (key_reg > rd_data_reg) lo_reg <= pmid_reg + 1'b1;
                else hi_reg <= pmid_reg;
            end
            if (cmd.chk) begin
                hit_reg <= (lo_reg < cnt_reg) && (rd_data_reg == key_reg);
                ptr_reg <= cnt_reg;
            end
            if (cmd.shift_wr) ptr_reg <= ptr_reg - 1'b1;
            if (cmd.ins_wr) cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign sts.search_done = (lo_reg >= hi_reg);
    assign sts.hit = hit_reg;
    assign sts.is_lookup = lookup_reg;
    assign sts.full = (cnt_reg >= CW'(TABLE_DEPTH));
    assign sts.shift_done = (ptr_reg == lo_reg);
    assign entry_count = CountBits'(cnt_reg);

endmodule

// ===== design/swt_ctrl.sv =====
// Controller: sequences search, hit check, shift and insert of one request.
module swt_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic              m_hit,
    output logic              m_full,
    output swt_pkg::swt_cmd_t cmd,
    input  swt_pkg::swt_sts_t sts
);
    import swt_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_PROBE  = 8'b0000_0010,
        ST_STEP   = 8'b0000_0100,
        ST_CHKRD  = 8'b0000_1000,
        ST_CHK    = 8'b0001_0000,
        ST_DECIDE = 8'b0010_0000,
        ST_SHRD   = 8'b0100_0000,
        ST_SHWR   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic ovalid_reg, ovalid_next, hit_reg, hit_next, full_reg, full_next;

    assign s_tready = (state_reg == ST_IDLE) && !ovalid_reg;
    assign m_tvalid = ovalid_reg;
    assign m_hit = hit_reg;
    assign m_full = full_reg;

    always_comb begin
        state_next = state_reg;
        ovalid_next = ovalid_reg;
        hit_next = hit_reg;
        full_next = full_reg;
        cmd = '0;
        if (ovalid_reg && m_tready) ovalid_next = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    cmd.load = 1'b1;
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (sts.search_done) begin
                    cmd.chk_rd = 1'b1;
                    state_next = ST_CHK;
                end else begin
                    cmd.probe = 1'b1;
                    state_next = ST_STEP;
                end
            end
            ST_STEP: begin
                cmd.step = 1'b1;
                state_next = ST_PROBE;
            end
            ST_CHKRD: begin
                cmd.chk_rd = 1'b1;
                state_next = ST_CHK;
            end
            ST_CHK: begin
                cmd.chk = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (sts.hit || sts.is_lookup || sts.full) begin
                    hit_next = sts.hit;
                    full_next = !sts.hit && !sts.is_lookup;
                    ovalid_next = 1'b1;
                    state_next = ST_IDLE;
                end else if (sts.shift_done) begin
                    cmd.ins_wr = 1'b1;
                    hit_next = 1'b0;
                    full_next = 1'b0;
                    ovalid_next = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    cmd.shift_rd = 1'b1;
                    state_next = ST_SHWR;
                end
            end
            ST_SHRD: begin
                cmd.shift_rd = 1'b1;
                state_next = ST_SHWR;
            end
            ST_SHWR: begin
                cmd.shift_wr = 1'b1;
                state_next = ST_DECIDE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ovalid_reg <= 1'b0;
            hit_reg <= 1'b0;
            full_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ovalid_reg <= ovalid_next;
            hit_reg <= hit_next;
            full_reg <= full_next;
        end
    end

endmodule

// ===== design/sorted_word_table_unit.sv =====
// Top level of the sorted word table: stream ports, APB register, control and datapath.
// Sorted word table. A request on the s_ stream carries req_type (tuser) and a
// ten-character CP1251 word (tdata). Inserts fold Cyrillic capitals to lower case
// and yo to ie, then place the word in ascending order; duplicates are left
// alone; a new word that finds the table full is dropped and flagged. Lookups
// compare the word as given. Characters past char_len (APB register at address 0,
// saturated to 3..10) are taken as zero.
// Each request yields one response on the m_ stream: hit, table_full and the
// entry count after the request.
// The response follows a binary search over the single read port of the word
// memory and, on an insert, a move of each stored entry at and above the
// insertion point up by one place (one read, one write each).
// One request is in flight at a time; a new request is taken the cycle after
// the response has been handed off.
// Reset clears the count and the char_len register (to 3); the word memory
// needs no clearing, since only entries below the count are used.
// A stalled receiver holds the response; no new request is taken meanwhile.
module sorted_word_table_unit #(
    parameter int unsigned TABLE_DEPTH = 1024,
    parameter int unsigned MAX_CHARS = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // word_high [15:0], word_low [79:16]
    input  logic [0:0]  s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // hit, table_full, entry_count [12:2], zeros
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import swt_pkg::*;

    logic [3:0] char_len_reg;
    swt_cmd_t cmd;
    swt_sts_t sts;
    logic hit, full;
    logic [CountBits-1:0] entry_count;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CHAR_LEN) ? {28'd0, char_len_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) char_len_reg <= 4'(MinChars);
        else if (psel && penable && pwrite && paddr[2] == REG_CHAR_LEN)
            char_len_reg <= pwdata[3:0];
    end

    swt_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_hit(hit), .m_full(full), .cmd(cmd), .sts(sts)
    );

    swt_datapath #(.TABLE_DEPTH(TABLE_DEPTH), .MAX_CHARS(MAX_CHARS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .req_type(s_tuser[0]), .word_high(s_tdata[15:0]), .word_low(s_tdata[79:16]),
        .char_len(char_len_reg), .entry_count(entry_count)
    );

    assign m_tdata = {3'd0, entry_count, full, hit};

endmodule

// ===== design/swt_checker.sv =====
// Port-level checks for the sorted word table, bound to the top level.
module swt_port_props (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [0:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("response dropped under stall");
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("request taken while response pending");
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("hit and full together");
    a_noimm: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !m_tvalid)
        else $error("response too early");
endmodule

bind sorted_word_table_unit swt_port_props u_port_props (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tuser(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
